### rtl/y2r_pkg.sv
// Shared types and constants for the 4:2:0 to RGB565 converter.
// Depends on nothing; y2r_chroma_coef, y2r_pixel_pack and the top level use its scoped names.
package y2r_pkg;

    localparam int MAX_PAIRS = 2048;
    localparam int MAX_LINES = 4096;
    localparam int COL_W     = $clog2(MAX_PAIRS);
    localparam int LINE_W    = $clog2(MAX_LINES);

    // Register widths fixed by the register map
    localparam int PPL_W     = 12;
    localparam int LPF_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    // Comparison widths for the end-of-line and end-of-frame tests
    localparam int COL_CMP_W  = (COL_W + 1 > PPL_W) ? COL_W + 1 : PPL_W;
    localparam int LINE_CMP_W = (LINE_W + 1 > LPF_W) ? LINE_W + 1 : LPF_W;

    localparam logic [PPL_W-1:0] PPL_RESET = PPL_W'(320);
    localparam logic [LPF_W-1:0] LPF_RESET = LPF_W'(480);

    // BT.601 coefficients, 8 fractional bits
    localparam logic signed [17:0] COEF_R  = 18'sd359;
    localparam logic signed [17:0] COEF_B  = 18'sd454;
    localparam logic signed [17:0] COEF_GB = 18'sd88;
    localparam logic signed [17:0] COEF_GR = 18'sd183;
    localparam logic [7:0]         CHROMA_BIAS = 8'h80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIRS_PER_LINE  = 2'd0,
        CFG_LINES_PER_FRAME = 2'd1,
        CFG_GREEN_ROUND     = 2'd2
    } t_cfg_idx;

    // Per-pair chroma contribution, already divided by 256 (floor)
    typedef struct packed {
        logic signed [8:0] r;
        logic signed [8:0] g;
        logic signed [8:0] b;
    } t_chroma_offs;

    // Chroma entry as stored: Cr in the high byte, Cb in the low byte
    typedef struct packed {
        logic [7:0] cr;
        logic [7:0] cb;
    } t_chroma_entry;

endpackage

### rtl/yuv420_to_rgb565_converter_unit.sv
// Top level of the 4:2:0 to RGB565 converter: raster counters, chroma line RAM,
// three-stage pipeline. Depends on y2r_pkg, y2r_chroma_ram, y2r_chroma_coef,
// y2r_pixel_pack.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+----------------------------------
//  pix in   | in        | i_pix_valid / o_pix_ready   | luma_first/second, chroma_blue/red
//  rgb out  | out       | o_rgb_valid / i_rgb_ready   | rgb_first/second, line/frame_last
//  cfg      | in        | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// One pixel pair per clock sustained while the output is not stalled; from accept to
// o_rgb_valid a pair passes RAM read, chroma products, pixel clamp and output register.
// The chroma RAM has one write and one read port; a pair either writes (even
// line) or reads (odd line) its column, so no port conflict arises.
// Synchronous active-low reset clears counters, valid bits and configuration registers;
// the RAM and data registers are not cleared. An output stall holds every full stage.
module yuv420_to_rgb565_converter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [y2r_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [y2r_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                           i_pix_valid,
    output logic                           o_pix_ready,
    input  logic [7:0]                     i_luma_first,
    input  logic [7:0]                     i_luma_second,
    input  logic [7:0]                     i_chroma_blue,
    input  logic [7:0]                     i_chroma_red,
    output logic                           o_rgb_valid,
    input  logic                           i_rgb_ready,
    output logic [15:0]                    o_rgb_first,
    output logic [15:0]                    o_rgb_second,
    output logic                           o_line_last,
    output logic                           o_frame_last
);

    localparam int COL_W      = y2r_pkg::COL_W;
    localparam int LINE_W     = y2r_pkg::LINE_W;
    localparam int COL_CMP_W  = y2r_pkg::COL_CMP_W;
    localparam int LINE_CMP_W = y2r_pkg::LINE_CMP_W;

    // configuration
    logic [y2r_pkg::PPL_W-1:0] r_pairs_per_line;
    logic [y2r_pkg::LPF_W-1:0] r_lines_per_frame;
    logic                      r_green_mode;

    // raster position
    logic [COL_W-1:0]  r_col, n_col;
    logic [LINE_W-1:0] r_line, n_line;

    logic                  pix_accept;
    logic                  line_end;
    logic                  frame_end;
    logic [COL_CMP_W-1:0]  col_next;
    logic [LINE_CMP_W-1:0] line_next;
    logic                  ram_we;
    logic                  ram_re;
    logic [15:0]           ram_rdata;

    // pipeline advance, output side first
    logic adv_out;
    logic adv_s2;
    logic adv_s1;

    // stage 1: item accepted, RAM read under way
    logic                   r_s1_valid;
    logic [7:0]             r_s1_y0, r_s1_y1;
    y2r_pkg::t_chroma_entry r_s1_entry;
    logic                   r_s1_odd;
    logic                   r_s1_line_last, r_s1_frame_last;
    y2r_pkg::t_chroma_entry s1_chroma;

    // stage 2: chroma offsets registered
    logic                  r_s2_valid;
    logic [7:0]            r_s2_y0, r_s2_y1;
    logic                  r_s2_line_last, r_s2_frame_last;
    y2r_pkg::t_chroma_offs s2_offs;
    logic [15:0]           s2_rgb0, s2_rgb1;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_rgb0, r_out_rgb1;
    logic        r_out_line_last, r_out_frame_last;

    assign adv_out     = !r_out_valid || i_rgb_ready;
    assign adv_s2      = !r_s2_valid || adv_out;
    assign adv_s1      = !r_s1_valid || adv_s2;
    assign o_pix_ready = adv_s1;
    assign pix_accept  = i_pix_valid && adv_s1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs_per_line  <= y2r_pkg::PPL_RESET;
            r_lines_per_frame <= y2r_pkg::LPF_RESET;
            r_green_mode      <= 1'b0;
        end else if (i_cfg_we) begin
            case (y2r_pkg::t_cfg_idx'(i_cfg_index))
                y2r_pkg::CFG_PAIRS_PER_LINE:
                    r_pairs_per_line <= i_cfg_data[y2r_pkg::PPL_W-1:0];
                y2r_pkg::CFG_LINES_PER_FRAME:
                    r_lines_per_frame <= i_cfg_data[y2r_pkg::LPF_W-1:0];
                y2r_pkg::CFG_GREEN_ROUND:
                    r_green_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // line and frame ends; a width of zero acts as one, heights below two as two
    always_comb begin
        col_next  = COL_CMP_W'(r_col) + COL_CMP_W'(1);
        line_next = LINE_CMP_W'(r_line) + LINE_CMP_W'(1);
        line_end  = (col_next >= COL_CMP_W'(r_pairs_per_line))
                 || (col_next >= COL_CMP_W'(y2r_pkg::MAX_PAIRS));
        frame_end = line_end
                 && (((r_lines_per_frame >= y2r_pkg::LPF_W'(2))
                      && (line_next >= LINE_CMP_W'(r_lines_per_frame)))
                  || ((r_lines_per_frame < y2r_pkg::LPF_W'(2))
                      && (line_next >= LINE_CMP_W'(2)))
                  || (line_next >= LINE_CMP_W'(y2r_pkg::MAX_LINES)));

        n_col  = r_col;
        n_line = r_line;
        if (pix_accept) begin
            if (line_end) begin
                n_col  = '0;
                n_line = frame_end ? '0 : line_next[LINE_W-1:0];
            end else begin
                n_col = col_next[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
        end else begin
            r_col  <= n_col;
            r_line <= n_line;
        end
    end

    // even lines store their chroma, odd lines fetch it
    assign ram_we = pix_accept && !r_line[0];
    assign ram_re = pix_accept && r_line[0];

    y2r_chroma_ram #(
        .DEPTH  (y2r_pkg::MAX_PAIRS),
        .DATA_W (16)
    ) u_chroma_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata ({i_chroma_red, i_chroma_blue}),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv_s1) begin
            r_s1_valid <= i_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_accept) begin
            r_s1_y0         <= i_luma_first;
            r_s1_y1         <= i_luma_second;
            r_s1_entry      <= {i_chroma_red, i_chroma_blue};
            r_s1_odd        <= r_line[0];
            r_s1_line_last  <= line_end;
            r_s1_frame_last <= frame_end;
        end
    end

    assign s1_chroma = r_s1_odd ? y2r_pkg::t_chroma_entry'(ram_rdata) : r_s1_entry;

    y2r_chroma_coef u_chroma_coef (
        .i_clk        (i_clk),
        .i_en         (adv_s2 && r_s1_valid),
        .i_entry      (s1_chroma),
        .i_green_mode (r_green_mode),
        .o_offs       (s2_offs)
    );

    // stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv_s2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s2 && r_s1_valid) begin
            r_s2_y0         <= r_s1_y0;
            r_s2_y1         <= r_s1_y1;
            r_s2_line_last  <= r_s1_line_last;
            r_s2_frame_last <= r_s1_frame_last;
        end
    end

    y2r_pixel_pack u_pixel_first (
        .i_luma   (r_s2_y0),
        .i_offs   (s2_offs),
        .o_rgb565 (s2_rgb0)
    );

    y2r_pixel_pack u_pixel_second (
        .i_luma   (r_s2_y1),
        .i_offs   (s2_offs),
        .o_rgb565 (s2_rgb1)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s2_valid) begin
            r_out_rgb0       <= s2_rgb0;
            r_out_rgb1       <= s2_rgb1;
            r_out_line_last  <= r_s2_line_last;
            r_out_frame_last <= r_s2_frame_last;
        end
    end

    assign o_rgb_valid  = r_out_valid;
    assign o_rgb_first  = r_out_rgb0;
    assign o_rgb_second = r_out_rgb1;
    assign o_line_last  = r_out_line_last;
    assign o_frame_last = r_out_frame_last;

    a_frame_has_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rgb_valid && o_frame_last |-> o_line_last)
        else $error("frame end beat without line end");

    a_ram_one_port_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("chroma RAM written and read by the same beat");

    a_col_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_accept && line_end |=> r_col == '0)
        else $error("column counter did not wrap at line end");

    a_line_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_accept && frame_end |=> r_line == '0)
        else $error("line counter did not wrap at frame end");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_pix_ready)
        else $error("input stalled with an empty output register");

endmodule

### rtl/y2r_chroma_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Stand-alone; holds the chroma line of the last even line.
module y2r_chroma_ram #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/y2r_chroma_coef.sv
// Chroma product stage: Cb/Cr times the BT.601 coefficients, floored by 256.
// Depends on y2r_pkg. Output is registered; one pair enters per enabled cycle.
module y2r_chroma_coef (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  y2r_pkg::t_chroma_entry i_entry,
    input  logic                  i_green_mode,
    output y2r_pkg::t_chroma_offs o_offs
);

    logic signed [17:0] cb;
    logic signed [17:0] cr;
    logic signed [17:0] prod_r;
    logic signed [17:0] prod_b;
    logic signed [17:0] prod_g;
    logic signed [17:0] prod_g_neg;
    logic signed [9:0]  g_floor;
    logic signed [9:0]  g_floor_neg;
    y2r_pkg::t_chroma_offs n_offs;
    y2r_pkg::t_chroma_offs r_offs;

    always_comb begin
        // byte - 128 is the byte with its top bit flipped, read as signed
        cb = 18'(signed'(i_entry.cb ^ y2r_pkg::CHROMA_BIAS));
        cr = 18'(signed'(i_entry.cr ^ y2r_pkg::CHROMA_BIAS));
        prod_r = cr * y2r_pkg::COEF_R;
        prod_b = cb * y2r_pkg::COEF_B;
        prod_g = cb * y2r_pkg::COEF_GB + cr * y2r_pkg::COEF_GR;
        prod_g_neg = -prod_g;
        g_floor = prod_g[17:8];
        g_floor_neg = -g_floor;

        n_offs.r = prod_r[16:8];
        n_offs.b = prod_b[16:8];
        // mode 0 subtracts floor(sum/256); mode 1 adds floor(-sum/256)
        if (i_green_mode) begin
            n_offs.g = prod_g_neg[16:8];
        end else begin
            n_offs.g = g_floor_neg[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_offs <= n_offs;
        end
    end

    assign o_offs = r_offs;

endmodule

### rtl/y2r_pixel_pack.sv
// One pixel: luma plus chroma offsets, clamp to 0..255, pack as RGB565.
// Depends on y2r_pkg for the offset struct.
module y2r_pixel_pack (
    input  logic [7:0]            i_luma,
    input  y2r_pkg::t_chroma_offs i_offs,
    output logic [15:0]           o_rgb565
);

    logic signed [9:0] sum_r;
    logic signed [9:0] sum_g;
    logic signed [9:0] sum_b;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;

    function automatic logic [7:0] clamp_u8(input logic signed [9:0] v);
        logic [7:0] res;
        if (v[9]) begin
            res = 8'd0;
        end else if (v[8]) begin
            res = 8'hff;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    always_comb begin
        sum_r = signed'({2'b00, i_luma}) + signed'({i_offs.r[8], i_offs.r});
        sum_g = signed'({2'b00, i_luma}) + signed'({i_offs.g[8], i_offs.g});
        sum_b = signed'({2'b00, i_luma}) + signed'({i_offs.b[8], i_offs.b});
        red   = clamp_u8(sum_r);
        green = clamp_u8(sum_g);
        blue  = clamp_u8(sum_b);
        o_rgb565 = {red[7:3], green[7:2], blue[7:3]};
    end

endmodule

### test/tb_yuv420_to_rgb565_converter_unit.sv
// Self-checking testbench for yuv420_to_rgb565_converter_unit: directed and random 4:2:0
// pair beats checked against a behavioral BT.601 RGB565 predictor with its own chroma line.
// Depends on rtl/y2r_pkg.sv and the converter RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb_yuv420_to_rgb565_converter_unit;

    localparam int CYCLE_LIMIT = 600_000;
    localparam int PIPE_DRAIN  = 10;
    localparam logic [y2r_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;

    typedef struct {
        logic [15:0] rgb_first;
        logic [15:0] rgb_second;
        logic        line_last;
        logic        frame_last;
    } t_rgb_pair;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [y2r_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [y2r_pkg::CFG_DAT_W-1:0] i_cfg_data;
    logic                          i_pix_valid;
    logic                          o_pix_ready;
    logic [7:0]                    i_luma_first;
    logic [7:0]                    i_luma_second;
    logic [7:0]                    i_chroma_blue;
    logic [7:0]                    i_chroma_red;
    logic                          o_rgb_valid;
    logic                          i_rgb_ready;
    logic [15:0]                   o_rgb_first;
    logic [15:0]                   o_rgb_second;
    logic                          o_line_last;
    logic                          o_frame_last;

    // predictor state
    logic [y2r_pkg::PPL_W-1:0] pred_ppl;
    logic [y2r_pkg::LPF_W-1:0] pred_lpf;
    logic                      pred_green_mode;
    y2r_pkg::t_chroma_entry    chroma_line [0:y2r_pkg::MAX_PAIRS-1];
    int                        col_pos;
    int                        line_pos;
    t_rgb_pair                 rgb_pending [$];

    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int src_idle_pct  = 0;
    int dst_stall_pct = 0;

    yuv420_to_rgb565_converter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pix_valid   (i_pix_valid),
        .o_pix_ready   (o_pix_ready),
        .i_luma_first  (i_luma_first),
        .i_luma_second (i_luma_second),
        .i_chroma_blue (i_chroma_blue),
        .i_chroma_red  (i_chroma_red),
        .o_rgb_valid   (o_rgb_valid),
        .i_rgb_ready   (i_rgb_ready),
        .o_rgb_first   (o_rgb_first),
        .o_rgb_second  (o_rgb_second),
        .o_line_last   (o_line_last),
        .o_frame_last  (o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Output beat checker and receiver stall generator
    always @(posedge i_clk) begin
        t_rgb_pair exp_pair;
        if (i_rst_n && o_rgb_valid && i_rgb_ready) begin
            if (rgb_pending.size() == 0) begin
                $error("unexpected output beat: rgb_first %h rgb_second %h",
                       o_rgb_first, o_rgb_second);
                err_cnt++;
            end else begin
                exp_pair = rgb_pending.pop_front();
                if (o_rgb_first !== exp_pair.rgb_first) begin
                    $error("rgb_first: expected %h, got %h", exp_pair.rgb_first, o_rgb_first);
                    err_cnt++;
                end
                if (o_rgb_second !== exp_pair.rgb_second) begin
                    $error("rgb_second: expected %h, got %h", exp_pair.rgb_second, o_rgb_second);
                    err_cnt++;
                end
                if (o_line_last !== exp_pair.line_last) begin
                    $error("line_last: expected %b, got %b", exp_pair.line_last, o_line_last);
                    err_cnt++;
                end
                if (o_frame_last !== exp_pair.frame_last) begin
                    $error("frame_last: expected %b, got %b", exp_pair.frame_last, o_frame_last);
                    err_cnt++;
                end
            end
        end
        i_rgb_ready <= ($urandom_range(99) >= dst_stall_pct);
    end

    function automatic logic [7:0] clamp_byte(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    // BT.601 with 8 fractional bits; >>> on int gives the floor division
    function automatic logic [15:0] pack_rgb565(input int luma, input int cb, input int cr,
                                                input logic mode);
        int         chroma_sum;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        chroma_sum = 88 * cb + 183 * cr;
        r = clamp_byte(luma + ((359 * cr) >>> 8));
        b = clamp_byte(luma + ((454 * cb) >>> 8));
        if (mode)
            g = clamp_byte((256 * luma - chroma_sum) >>> 8);
        else
            g = clamp_byte(luma - (chroma_sum >>> 8));
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    task automatic compute_rgb_pair(input logic [7:0] y0, input logic [7:0] y1,
                                    input logic [7:0] cb_byte, input logic [7:0] cr_byte);
        t_rgb_pair              res;
        y2r_pkg::t_chroma_entry entry;
        int                     eff_width;
        int                     eff_height;
        int                     cb;
        int                     cr;
        eff_width  = (pred_ppl == 0) ? 1 :
                     ((pred_ppl > y2r_pkg::MAX_PAIRS) ? y2r_pkg::MAX_PAIRS : int'(pred_ppl));
        eff_height = (pred_lpf < 2) ? 2 :
                     ((pred_lpf > y2r_pkg::MAX_LINES) ? y2r_pkg::MAX_LINES : int'(pred_lpf));
        // even lines store their chroma, odd lines reuse the one above
        if (line_pos % 2 == 0) begin
            entry.cb = cb_byte;
            entry.cr = cr_byte;
            chroma_line[col_pos % y2r_pkg::MAX_PAIRS] = entry;
        end else begin
            entry = chroma_line[col_pos % y2r_pkg::MAX_PAIRS];
        end
        cb = int'(entry.cb) - 128;
        cr = int'(entry.cr) - 128;
        res.rgb_first  = pack_rgb565(y0, cb, cr, pred_green_mode);
        res.rgb_second = pack_rgb565(y1, cb, cr, pred_green_mode);
        res.line_last  = (col_pos + 1 >= eff_width);
        res.frame_last = res.line_last && (line_pos + 1 >= eff_height);
        rgb_pending.push_back(res);
        if (res.line_last) begin
            col_pos  = 0;
            line_pos = res.frame_last ? 0 : line_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    task automatic write_reg(input logic [y2r_pkg::CFG_IDX_W-1:0] idx,
                             input logic [y2r_pkg::CFG_DAT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            y2r_pkg::CFG_PAIRS_PER_LINE:  pred_ppl = data[y2r_pkg::PPL_W-1:0];
            y2r_pkg::CFG_LINES_PER_FRAME: pred_lpf = data[y2r_pkg::LPF_W-1:0];
            y2r_pkg::CFG_GREEN_ROUND:     pred_green_mode = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_idle_mode(input int sel);
        case (sel % 4)
            0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
            1: begin src_idle_pct = 66; dst_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  dst_stall_pct = 66; end
            default: begin src_idle_pct = 13; dst_stall_pct = 13; end
        endcase
    endtask

    task automatic send_pixel_pair(input logic [7:0] y0, input logic [7:0] y1,
                                   input logic [7:0] cb, input logic [7:0] cr);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_pix_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        i_pix_valid   <= 1'b1;
        i_luma_first  <= y0;
        i_luma_second <= y1;
        i_chroma_blue <= cb;
        i_chroma_red  <= cr;
        @(posedge i_clk);
        while (!o_pix_ready)
            @(posedge i_clk);
        compute_rgb_pair(y0, y1, cb, cr);
    endtask

    // Hold the sender off until every pending pair is out, plus pipeline slack
    task automatic wait_for_drain();
        i_pix_valid <= 1'b0;
        while (rgb_pending.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_sample_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random pairs until at least n sent and the raster is back at a frame start
    task automatic send_frames(input int n);
        int sent;
        sent = 0;
        do begin
            send_pixel_pair(pick_sample_byte(), pick_sample_byte(),
                            pick_sample_byte(), pick_sample_byte());
            sent++;
            if ($urandom_range(79) == 0)
                wait_for_drain();
        end while (sent < n || col_pos != 0 || line_pos != 0);
    endtask

    task automatic test_reset_defaults();
        set_idle_mode(0);
        send_pixel_pair(8'h00, 8'hff, 8'h00, 8'h00);
        send_pixel_pair(8'hff, 8'h00, 8'hff, 8'hff);
        send_pixel_pair(8'hff, 8'hff, 8'h00, 8'hff);
        send_pixel_pair(8'h00, 8'h00, 8'hff, 8'h00);
        send_pixel_pair(8'h80, 8'h7f, 8'h80, 8'h80);
        wait_for_drain();
    endtask

    // Column already past the new width: the next pair must close the line
    task automatic test_width_shrink_midline();
        set_idle_mode(1);
        write_reg(y2r_pkg::CFG_PAIRS_PER_LINE, 13'h1002);
        send_pixel_pair(8'h40, 8'hc0, 8'h11, 8'hee);
        wait_for_drain();
    endtask

    // Height 0 behaves as 2, so this odd line closes the frame
    task automatic test_height_floor();
        set_idle_mode(2);
        write_reg(y2r_pkg::CFG_LINES_PER_FRAME, 13'd0);
        send_pixel_pair(8'h10, 8'hf0, 8'h00, 8'h00);
        send_pixel_pair(8'hf0, 8'h10, 8'hff, 8'hff);
        wait_for_drain();
    endtask

    // Width 0 behaves as 1; odd height ends on an even line with its own chroma
    task automatic test_width_zero_odd_height();
        set_idle_mode(3);
        write_reg(y2r_pkg::CFG_PAIRS_PER_LINE, 13'd0);
        write_reg(y2r_pkg::CFG_LINES_PER_FRAME, 13'd3);
        send_pixel_pair(8'h60, 8'h90, 8'h20, 8'he0);
        send_pixel_pair(8'h90, 8'h60, 8'hff, 8'h00);
        send_pixel_pair(8'hff, 8'h00, 8'h00, 8'hff);
        wait_for_drain();
    endtask

    // Chroma 0x81/0x81 puts the green sum off a multiple of 256, so the modes differ
    task automatic test_green_round_mode();
        set_idle_mode(0);
        write_reg(y2r_pkg::CFG_GREEN_ROUND, 13'd1);
        write_reg(CFG_IDX_NONE, 13'h1ffe);
        write_reg(y2r_pkg::CFG_PAIRS_PER_LINE, 13'd2);
        write_reg(y2r_pkg::CFG_LINES_PER_FRAME, 13'd2);
        send_pixel_pair(8'h80, 8'h01, 8'h81, 8'h81);
        send_pixel_pair(8'hfe, 8'h7f, 8'h7f, 8'h81);
        send_pixel_pair(8'h02, 8'hff, 8'h00, 8'h00);
        send_pixel_pair(8'h55, 8'haa, 8'h00, 8'h00);
        wait_for_drain();
    endtask

    task automatic test_random_frames(input int phases, input int items_per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            set_idle_mode(ph);
            write_reg(y2r_pkg::CFG_PAIRS_PER_LINE, {1'($urandom), 12'($urandom_range(8))});
            write_reg(y2r_pkg::CFG_LINES_PER_FRAME, 13'($urandom_range(7)));
            write_reg(y2r_pkg::CFG_GREEN_ROUND, {12'($urandom), 1'($urandom)});
            if ($urandom_range(3) == 0)
                write_reg(CFG_IDX_NONE, 13'($urandom));
            send_frames(items_per_phase);
            wait_for_drain();
        end
    endtask

    initial begin
        pred_ppl        = y2r_pkg::PPL_RESET;
        pred_lpf        = y2r_pkg::LPF_RESET;
        pred_green_mode = 1'b0;
        col_pos         = 0;
        line_pos        = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= y2r_pkg::CFG_PAIRS_PER_LINE;
        i_cfg_data    <= '0;
        i_pix_valid   <= 1'b0;
        i_luma_first  <= '0;
        i_luma_second <= '0;
        i_chroma_blue <= '0;
        i_chroma_red  <= '0;
        i_rgb_ready   <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_width_shrink_midline();
        test_height_floor();
        test_width_zero_odd_height();
        test_green_round_mode();
        test_random_frames(6, 140);
        test_random_frames(6, 140);

        wait_for_drain();
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
